/* rtl/core/bwrm_pkg.sv */
package bwrm_pkg;

    localparam int MAX_BUCKETS = 32;
    localparam int SLOT_W      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CNT_W       = $clog2(MAX_BUCKETS + 1);

    localparam int TIME_W      = 64;
    localparam int BYTES_W     = 32;
    localparam int SUM_W       = 64;
    localparam int NB_W        = 5;
    localparam int DUR_W       = 32;
    localparam int SPAN_W      = NB_W + DUR_W;
    localparam int COUNT_OUT_W = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_NUM_BUCKETS      = 2'd0;
    localparam t_cfg_idx CFG_BUCKET_DURATION  = 2'd1;
    localparam t_cfg_idx CFG_MAX_WINDOW_BYTES = 2'd2;

    localparam logic [NB_W-1:0]  RST_NUM_BUCKETS = 5'd1;
    localparam logic [DUR_W-1:0] RST_DURATION    = 32'd1000;
    localparam logic [SUM_W-1:0] RST_MAX_BYTES   = 64'd0;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(MAX_BUCKETS - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(MAX_BUCKETS)) begin
            s = s - (CNT_W + 1)'(MAX_BUCKETS);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

/* rtl/core/bwrm_in_if.sv */
interface bwrm_in_if;
    logic                           valid;
    logic                           ready;
    logic [bwrm_pkg::TIME_W-1:0]    now_ms;
    logic [bwrm_pkg::BYTES_W-1:0]   byte_count;

    modport source (output valid, output now_ms, output byte_count, input ready);
    modport sink   (input valid, input now_ms, input byte_count, output ready);
endinterface

/* rtl/core/bwrm_out_if.sv */
interface bwrm_out_if;
    logic                               valid;
    logic                               ready;
    logic                               rate_exceeded;
    logic [bwrm_pkg::SUM_W-1:0]         total_bytes;
    logic [bwrm_pkg::COUNT_OUT_W-1:0]   bucket_count;
    logic                               ring_overflow;

    modport source (output valid, output rate_exceeded, output total_bytes,
                    output bucket_count, output ring_overflow, input ready);
    modport sink   (input valid, input rate_exceeded, input total_bytes,
                    input bucket_count, input ring_overflow, output ready);
endinterface

/* rtl/core/bwrm_cfg_if.sv */
interface bwrm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bwrm_pkg::CFG_IDX_W-1:0]     index;
    logic [bwrm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/bucketed_window_rate_monitor.sv */
// channel   dir   payload                                            beat when
// i_cfg     in    index, data                                        valid & ready
// i_in      in    now_ms, byte_count                                 valid & ready
// o_out     out   rate_exceeded, total_bytes, bucket_count,          valid & ready
//                 ring_overflow
//
// an item runs through span, floor, the drop scan, check, update and the sum before the next
// input beat is taken; one memory read per cycle in the drop scan and the sum
// i_in.ready is high only between items; i_cfg.ready is always high
// a finished result waits in the output register while the next item runs, which then
// holds in its last sum cycle until the register is free
// reset is synchronous, active low, and empties the ring
module bucketed_window_rate_monitor (
    input logic         i_clk,
    input logic         i_rst_n,
    bwrm_cfg_if.sink    i_cfg,
    bwrm_in_if.sink     i_in,
    bwrm_out_if.source  o_out
);
    import bwrm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SPAN   = 7'b0000010,
        S_FLOOR  = 7'b0000100,
        S_PRUNE  = 7'b0001000,
        S_CHECK  = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_SUM    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [NB_W-1:0]   r_num_buckets, n_num_buckets;
    logic [DUR_W-1:0]  r_duration, n_duration;
    logic [SUM_W-1:0]  r_max_bytes, n_max_bytes;

    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_rd_vld, n_rd_vld;
    logic              r_out_valid, n_out_valid;

    logic [TIME_W-1:0]      r_now, n_now;
    logic [BYTES_W-1:0]     r_size, n_size;
    logic [SPAN_W-1:0]      r_span, n_span;
    logic [TIME_W-1:0]      r_floor, n_floor;
    logic                   r_contains, n_contains;
    logic [SUM_W-1:0]       r_sum_new, n_sum_new;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic                   r_ovf, n_ovf;
    logic [SLOT_W-1:0]      r_ptr, n_ptr;
    logic [SUM_W-1:0]       r_acc, n_acc;
    logic                   r_out_exceeded, n_out_exceeded;
    logic [SUM_W-1:0]       r_out_total, n_out_total;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;
    logic                   r_out_ovf, n_out_ovf;

    logic [SLOT_W-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_waddr;
    logic              ram_we_start;
    logic              ram_we_bytes;
    logic [SUM_W-1:0]  ram_wdata_bytes;
    logic [TIME_W-1:0] rd_start;
    logic [SUM_W-1:0]  rd_bytes;

    logic [TIME_W:0]   w_end;
    logic              w_ends_before;
    logic [TIME_W:0]   w_diff;
    logic              w_contains;
    logic [SLOT_W-1:0] w_newest;
    logic              w_out_free;
    logic              w_in_beat;

    bwrm_ram #(.WIDTH(TIME_W), .DEPTH(MAX_BUCKETS)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we_start),
        .i_waddr (ram_waddr),
        .i_wdata (r_now),
        .i_raddr (ram_raddr),
        .o_rdata (rd_start)
    );

    bwrm_ram #(.WIDTH(SUM_W), .DEPTH(MAX_BUCKETS)) u_bytes_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we_bytes),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata_bytes),
        .i_raddr (ram_raddr),
        .o_rdata (rd_bytes)
    );

    assign i_cfg.ready         = 1'b1;
    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.rate_exceeded = r_out_exceeded;
    assign o_out.total_bytes   = r_out_total;
    assign o_out.bucket_count  = r_out_count;
    assign o_out.ring_overflow = r_out_ovf;

    assign w_in_beat  = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;

    // bucket end in 65 bits, so an end past the time range never looks old
    assign w_end         = {1'b0, rd_start} + (TIME_W + 1)'(r_duration);
    assign w_ends_before = w_end < {1'b0, r_floor};

    // borrow out means now lies before the bucket start
    assign w_diff     = {1'b0, r_now} - {1'b0, rd_start};
    assign w_contains = (r_live != '0) && !w_diff[TIME_W]
                        && (w_diff[TIME_W-1:0] < TIME_W'(r_duration));

    assign w_newest = slot_add(r_oldest, r_live - 1'b1);

    always_comb begin
        n_state        = r_state;
        n_num_buckets  = r_num_buckets;
        n_duration     = r_duration;
        n_max_bytes    = r_max_bytes;
        n_oldest       = r_oldest;
        n_live         = r_live;
        n_idx          = r_idx;
        n_rd_vld       = r_rd_vld;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_now          = r_now;
        n_size         = r_size;
        n_span         = r_span;
        n_floor        = r_floor;
        n_contains     = r_contains;
        n_sum_new      = r_sum_new;
        n_slot         = r_slot;
        n_ovf          = r_ovf;
        n_ptr          = r_ptr;
        n_acc          = r_acc;
        n_out_exceeded = r_out_exceeded;
        n_out_total    = r_out_total;
        n_out_count    = r_out_count;
        n_out_ovf      = r_out_ovf;

        ram_raddr       = r_ptr;
        ram_waddr       = r_slot;
        ram_we_start    = 1'b0;
        ram_we_bytes    = 1'b0;
        ram_wdata_bytes = r_sum_new;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NUM_BUCKETS:      n_num_buckets = i_cfg.data[NB_W-1:0];
                CFG_BUCKET_DURATION:  n_duration    = i_cfg.data[DUR_W-1:0];
                CFG_MAX_WINDOW_BYTES: n_max_bytes   = i_cfg.data[SUM_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_now   = i_in.now_ms;
                    n_size  = i_in.byte_count;
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                if (r_num_buckets == '0) begin
                    n_span = '0;
                end else begin
                    n_span = SPAN_W'(r_num_buckets - 1'b1) * SPAN_W'(r_duration);
                end
                n_state = S_FLOOR;
            end
            S_FLOOR: begin
                if (r_now > TIME_W'(r_span)) begin
                    n_floor = r_now - TIME_W'(r_span);
                end else begin
                    n_floor = '0;
                end
                ram_raddr = r_oldest;
                n_state   = S_PRUNE;
            end
            S_PRUNE: begin
                // rd_start holds the current oldest bucket
                if (r_live != '0 && w_ends_before) begin
                    n_oldest  = slot_inc(r_oldest);
                    n_live    = r_live - 1'b1;
                    ram_raddr = slot_inc(r_oldest);
                end else begin
                    ram_raddr = w_newest;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                ram_raddr  = w_newest;
                n_contains = w_contains;
                n_sum_new  = sat_add(rd_bytes, SUM_W'(r_size));
                n_slot     = w_newest;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                if (r_contains) begin
                    ram_waddr       = r_slot;
                    ram_we_bytes    = 1'b1;
                    ram_wdata_bytes = r_sum_new;
                    n_ovf           = 1'b0;
                end else begin
                    ram_we_start    = 1'b1;
                    ram_we_bytes    = 1'b1;
                    ram_wdata_bytes = SUM_W'(r_size);
                    if (r_live == CNT_W'(MAX_BUCKETS)) begin
                        // full ring: the new bucket takes the evicted oldest slot
                        ram_waddr = r_oldest;
                        n_oldest  = slot_inc(r_oldest);
                        n_ovf     = 1'b1;
                    end else begin
                        ram_waddr = slot_add(r_oldest, r_live);
                        n_live    = r_live + 1'b1;
                        n_ovf     = 1'b0;
                    end
                end
                n_ptr    = n_oldest;
                n_idx    = '0;
                n_rd_vld = 1'b0;
                n_acc    = '0;
                n_state  = S_SUM;
            end
            S_SUM: begin
                if (r_rd_vld) begin
                    n_acc = sat_add(r_acc, rd_bytes);
                end
                if (r_idx != r_live) begin
                    n_rd_vld = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_ptr    = slot_inc(r_ptr);
                end else begin
                    n_rd_vld = 1'b0;
                    // last beat of data is folded in before the result is loaded
                    if (!r_rd_vld && w_out_free) begin
                        n_out_valid    = 1'b1;
                        n_out_total    = r_acc;
                        n_out_exceeded = r_acc > r_max_bytes;
                        n_out_count    = COUNT_OUT_W'(r_live);
                        n_out_ovf      = r_ovf;
                        n_state        = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_buckets <= RST_NUM_BUCKETS;
            r_duration    <= RST_DURATION;
            r_max_bytes   <= RST_MAX_BYTES;
            r_oldest      <= '0;
            r_live        <= '0;
            r_idx         <= '0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_num_buckets <= n_num_buckets;
            r_duration    <= n_duration;
            r_max_bytes   <= n_max_bytes;
            r_oldest      <= n_oldest;
            r_live        <= n_live;
            r_idx         <= n_idx;
            r_rd_vld      <= n_rd_vld;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now          <= n_now;
        r_size         <= n_size;
        r_span         <= n_span;
        r_floor        <= n_floor;
        r_contains     <= n_contains;
        r_sum_new      <= n_sum_new;
        r_slot         <= n_slot;
        r_ovf          <= n_ovf;
        r_ptr          <= n_ptr;
        r_acc          <= n_acc;
        r_out_exceeded <= n_out_exceeded;
        r_out_total    <= n_out_total;
        r_out_count    <= n_out_count;
        r_out_ovf      <= n_out_ovf;
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(MAX_BUCKETS))
        else $error("live bucket count beyond ring size");

    a_beat_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SPAN))
        else $error("accepted item did not start the sequence");

    a_update_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> (r_live != '0))
        else $error("ring empty after bucket update");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ring_overflow)
            |-> (o_out.bucket_count == COUNT_OUT_W'(MAX_BUCKETS)))
        else $error("eviction reported with ring not full");
`endif

endmodule

/* rtl/core/bwrm_ram.sv */
module bwrm_ram #(
    parameter int  WIDTH  = 64,
    parameter int  DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* test/bucketed_window_rate_monitor_tb.sv */
`timescale 1ns / 1ps

module bucketed_window_rate_monitor_tb;
    import bwrm_pkg::*;

    localparam t_cfg_idx CFG_SPARE_IDX = 2'd3;
    localparam int       PHASES        = 13;
    localparam int       PHASE_ITEMS   = 50;
    localparam int       LONG_HOLD     = 300;

    typedef struct packed {
        logic                   rate_exceeded;
        logic [SUM_W-1:0]       total_bytes;
        logic [COUNT_OUT_W-1:0] bucket_count;
        logic                   ring_overflow;
    } t_rate_result;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] value;
        logic [TIME_W-1:0]     now;
        logic [BYTES_W-1:0]    nbytes;
        logic [7:0]            reps;
        logic                  typed;
        t_rate_result          want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bwrm_cfg_if cfg_bus ();
    bwrm_in_if  in_bus ();
    bwrm_out_if out_bus ();

    bucketed_window_rate_monitor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // window predictor: own copy of the ring and the registers
    logic [TIME_W-1:0] win_start [MAX_BUCKETS];
    logic [SUM_W-1:0]  win_bytes [MAX_BUCKETS];
    int                head_slot = 0;
    int                live_cnt  = 0;
    logic [SUM_W-1:0]  win_total = '0;
    logic [NB_W-1:0]   nb_q      = RST_NUM_BUCKETS;
    logic [DUR_W-1:0]  dur_q     = RST_DURATION;
    logic [SUM_W-1:0]  limit_q   = RST_MAX_BYTES;

    t_rate_result expected_q [$];
    t_row         plan [$];
    int           fail_cnt = 0;
    bit           idle_on  = 1'b1;

    function automatic t_rate_result predict_window(input logic [TIME_W-1:0]  now,
                                                    input logic [BYTES_W-1:0] nbytes);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] floor_t;
        logic [TIME_W:0]   end_t;
        logic [SUM_W:0]    acc;
        int                newest;
        t_rate_result      res;
        span    = (nb_q == '0) ? '0 : TIME_W'(nb_q - 1'b1) * TIME_W'(dur_q);
        floor_t = (now > span) ? now - span : '0;
        res     = '0;
        // drop buckets that end before the floor; an end past 2^64-1 never drops
        while (live_cnt > 0) begin
            end_t = {1'b0, win_start[head_slot]} + (TIME_W + 1)'(dur_q);
            if (end_t >= {1'b0, floor_t}) break;
            head_slot = (head_slot + 1) % MAX_BUCKETS;
            live_cnt--;
        end
        newest = (head_slot + live_cnt + MAX_BUCKETS - 1) % MAX_BUCKETS;
        if (live_cnt > 0 && now >= win_start[newest]
                && (now - win_start[newest]) < TIME_W'(dur_q)) begin
            acc = {1'b0, win_bytes[newest]} + (SUM_W + 1)'(nbytes);
            win_bytes[newest] = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
        end else begin
            if (live_cnt >= MAX_BUCKETS) begin
                head_slot         = (head_slot + 1) % MAX_BUCKETS;
                live_cnt          = MAX_BUCKETS - 1;
                res.ring_overflow = 1'b1;
            end
            newest            = (head_slot + live_cnt) % MAX_BUCKETS;
            win_start[newest] = now;
            win_bytes[newest] = SUM_W'(nbytes);
            live_cnt++;
        end
        win_total = '0;
        for (int k = 0; k < live_cnt; k++) begin
            acc       = {1'b0, win_total} + {1'b0, win_bytes[(head_slot + k) % MAX_BUCKETS]};
            win_total = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
        end
        res.total_bytes   = win_total;
        res.rate_exceeded = (win_total > limit_q);
        res.bucket_count  = COUNT_OUT_W'(live_cnt);
        return res;
    endfunction

    function automatic t_row cfg_row(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        t_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    function automatic t_row item_row(input logic [TIME_W-1:0] now,
                                      input logic [BYTES_W-1:0] nbytes, input int reps);
        t_row r;
        r        = '0;
        r.kind   = ROW_ITEM;
        r.now    = now;
        r.nbytes = nbytes;
        r.reps   = 8'(reps);
        return r;
    endfunction

    function automatic t_row typed_row(input logic [TIME_W-1:0] now,
                                       input logic [BYTES_W-1:0] nbytes,
                                       input t_rate_result want);
        t_row r;
        r       = item_row(now, nbytes, 1);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic void add_row(input t_row r);
        plan.insert(plan.size(), r);
    endfunction

    // register writes wait until every result is back, so the block is idle
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        in_bus.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        case (idx)
            CFG_NUM_BUCKETS:      nb_q    = value[NB_W-1:0];
            CFG_BUCKET_DURATION:  dur_q   = value[DUR_W-1:0];
            CFG_MAX_WINDOW_BYTES: limit_q = value;
            default: ;
        endcase
    endtask

    // valid stays high across back-to-back beats
    task automatic push_item(input logic [TIME_W-1:0] now, input logic [BYTES_W-1:0] nbytes,
                             input logic typed, input t_rate_result want);
        int           gap;
        t_rate_result pred;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        cfg_bus.valid <= 1'b0;
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.now_ms     <= now;
        in_bus.byte_count <= nbytes;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        pred = predict_window(now, nbytes);
        expected_q.insert(expected_q.size(), typed ? want : pred);
    endtask

    initial begin
        logic [TIME_W-1:0]     t;
        logic [CFG_DATA_W-1:0] val;
        logic [BYTES_W-1:0]    nbytes;
        logic [NB_W-1:0]       nb;
        logic [DUR_W-1:0]      dur;
        i_rst_n           <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_NUM_BUCKETS;
        cfg_bus.data      <= '0;
        in_bus.valid      <= 1'b0;
        in_bus.now_ms     <= '0;
        in_bus.byte_count <= '0;
        for (int k = 0; k < MAX_BUCKETS; k++) begin
            win_start[k] = '0;
            win_bytes[k] = '0;
        end

        // reset defaults first, then every register and the corner timings
        add_row(typed_row(64'd0, 32'd0, '{1'b0, 64'd0, 6'd1, 1'b0}));
        add_row(typed_row(64'd999, 32'hFFFF_FFFF, '{1'b1, 64'hFFFF_FFFF, 6'd1, 1'b0}));
        add_row(item_row(64'd1000, 32'd1, 1));
        add_row(cfg_row(CFG_MAX_WINDOW_BYTES, '1));
        add_row(cfg_row(CFG_NUM_BUCKETS, 64'd31));
        add_row(cfg_row(CFG_BUCKET_DURATION, 64'd1));
        add_row(item_row(64'd1001, 32'd5, 1));
        add_row(item_row(64'd1500, 32'd7, 1));
        add_row(item_row(64'd1531, 32'd9, 1));
        add_row(item_row(64'd1532, 32'd0, 1));
        // zero span: floor is the timestamp itself
        add_row(cfg_row(CFG_NUM_BUCKETS, 64'd0));
        add_row(item_row(64'd1532, 32'd3, 1));
        add_row(item_row(64'd1533, 32'd4, 1));
        add_row(item_row(64'd1540, 32'd1, 1));
        // bucket end beyond the time range
        add_row(cfg_row(CFG_BUCKET_DURATION, '1));
        add_row(cfg_row(CFG_NUM_BUCKETS, 64'hFFFF_FFFF_FFFF_FFE5));
        add_row(item_row(64'hFFFF_FFFF_FFFF_FF00, 32'd100, 1));
        add_row(item_row(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1));
        // time going backwards
        add_row(item_row(64'd5, 32'd1, 1));
        add_row(cfg_row(CFG_SPARE_IDX, 64'hA5A5_5A5A_F0F0_0F0F));
        add_row(cfg_row(CFG_MAX_WINDOW_BYTES, 64'd0));
        // zero duration: every beat opens a bucket until the ring wraps
        add_row(cfg_row(CFG_BUCKET_DURATION, 64'd0));
        add_row(cfg_row(CFG_NUM_BUCKETS, 64'd31));
        add_row(item_row(64'd77, 32'd2, 34));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                cfg_write(plan[r].idx, plan[r].value);
            end else begin
                for (int k = 0; k < plan[r].reps; k++) begin
                    push_item(plan[r].now, plan[r].nbytes, plan[r].typed, plan[r].want);
                end
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       nb = 5'd0;
                1:       nb = 5'd1;
                2:       nb = 5'd31;
                default: nb = 5'($urandom_range(2, 30));
            endcase
            case ($urandom_range(0, 5))
                0:       dur = 32'd0;
                1:       dur = 32'd1;
                2:       dur = 32'hFFFF_FFFF;
                3:       dur = $urandom;
                default: dur = 32'($urandom_range(1, 64));
            endcase
            val = {$urandom, $urandom};
            val[NB_W-1:0] = nb;
            cfg_write(CFG_NUM_BUCKETS, val);
            val = {$urandom, $urandom};
            val[DUR_W-1:0] = dur;
            cfg_write(CFG_BUCKET_DURATION, val);
            case ($urandom_range(0, 4))
                0:       val = '0;
                1:       val = '1;
                2:       val = {30'd0, 2'($urandom_range(0, 3)), $urandom};
                3:       val = {$urandom, $urandom};
                default: val = 64'($urandom_range(0, 4000));
            endcase
            cfg_write(CFG_MAX_WINDOW_BYTES, val);
            if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE_IDX, {$urandom, $urandom});

            case ($urandom_range(0, 3))
                0:       t = '0;
                1:       t = {$urandom, $urandom};
                2:       t = '1 - 64'($urandom_range(0, 5000));
                default: t = 64'($urandom_range(0, 100000));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    if (dur == 0)
                        t = t + (($urandom_range(0, 3) == 0) ? 64'd1 : 64'd0);
                    else
                        t = t + ((64'(dur) * 64'($urandom_range(0, 12))) >> 2)
                              + 64'($urandom_range(0, 2));
                end else if ($urandom_range(0, 1) == 0) begin
                    t = {$urandom, $urandom};
                end else begin
                    t = t - 64'($urandom_range(0, 3)) * 64'(dur) - 64'd1;
                end
                case ($urandom_range(0, 3))
                    0:       nbytes = $urandom;
                    1:       nbytes = ($urandom_range(0, 1) == 0) ? '0 : '1;
                    default: nbytes = 32'($urandom_range(0, 300));
                endcase
                push_item(t, nbytes, 1'b0, '0);
            end
        end

        in_bus.valid  <= 1'b0;
        cfg_bus.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: random stalls, two long hold-offs that back up the input
    initial begin
        int           hold;
        int           seen;
        t_rate_result want;
        seen = 0;
        out_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = idle_on ? $urandom_range(0, 4) : 0;
            if (seen == 150 || seen == 450) hold = LONG_HOLD;
            if (hold != 0) begin
                out_bus.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
            seen++;
            if (expected_q.size() == 0) begin
                $error("result beat with no expected result pending");
                fail_cnt++;
            end else begin
                want = expected_q[0];
                expected_q.delete(0);
                if (out_bus.rate_exceeded !== want.rate_exceeded) begin
                    $error("rate_exceeded: expected %0h, got %0h",
                           want.rate_exceeded, out_bus.rate_exceeded);
                    fail_cnt++;
                end
                if (out_bus.total_bytes !== want.total_bytes) begin
                    $error("total_bytes: expected %0h, got %0h",
                           want.total_bytes, out_bus.total_bytes);
                    fail_cnt++;
                end
                if (out_bus.bucket_count !== want.bucket_count) begin
                    $error("bucket_count: expected %0d, got %0d",
                           want.bucket_count, out_bus.bucket_count);
                    fail_cnt++;
                end
                if (out_bus.ring_overflow !== want.ring_overflow) begin
                    $error("ring_overflow: expected %0h, got %0h",
                           want.ring_overflow, out_bus.ring_overflow);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/bwrm_pkg.sv
rtl/core/bwrm_in_if.sv
rtl/core/bwrm_out_if.sv
rtl/core/bwrm_cfg_if.sv
rtl/core/bwrm_ram.sv
rtl/core/bucketed_window_rate_monitor.sv
test/bucketed_window_rate_monitor_tb.sv
